// File: src/ubx_rx_pkg.sv
// ----------------------------------------------------------------------------
// ubx_rx_pkg
// Shared constants, types and lookup functions for the UBX frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ubx_rx_pkg;

   // frame limits and sync pattern
   localparam int MAX_FRAME_BYTES = 512;
   localparam logic [16:0] MAX_FRAME_LIMIT = 17'(MAX_FRAME_BYTES);
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // message classes on the wire
   localparam logic [7:0] CLASS_NAV = 8'h01;
   localparam logic [7:0] CLASS_CFG = 8'h06;
   localparam logic [7:0] CLASS_ACK = 8'h05;

   // message ids on the wire
   localparam logic [7:0] ID_POSLLH  = 8'h02;
   localparam logic [7:0] ID_SOL     = 8'h06;
   localparam logic [7:0] ID_TIMEUTC = 8'h21;
   localparam logic [7:0] ID_SVINFO  = 8'h30;
   localparam logic [7:0] ID_VELNED  = 8'h12;
   localparam logic [7:0] ID_NAV5    = 8'h24;
   localparam logic [7:0] ID_ACK     = 8'h01;
   localparam logic [7:0] ID_NAK     = 8'h00;

   // class codes held while waiting for the id
   localparam logic [2:0] KIND_NAV = 3'd0;
   localparam logic [2:0] KIND_CFG = 3'd1;
   localparam logic [2:0] KIND_ACK = 3'd2;

   // message codes
   localparam logic [2:0] MSG_POSLLH  = 3'd0;
   localparam logic [2:0] MSG_SOL     = 3'd1;
   localparam logic [2:0] MSG_TIMEUTC = 3'd2;
   localparam logic [2:0] MSG_SVINFO  = 3'd3;
   localparam logic [2:0] MSG_VELNED  = 3'd4;
   localparam logic [2:0] MSG_NAV5    = 3'd5;
   localparam logic [2:0] MSG_ACK     = 3'd6;
   localparam logic [2:0] MSG_NAK     = 3'd7;

   // per-beat status codes
   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_PAYLOAD   = 3'd1,
      STATUS_CHECK1    = 3'd2,
      STATUS_GOOD      = 3'd3,
      STATUS_BAD_SUM   = 3'd4,
      STATUS_TOO_LONG  = 3'd5
   } status_type;

   // one result beat
   typedef struct packed {
      status_type  status;
      logic [2:0]  message_code;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [15:0] payload_length;
   } result_type;

   // lookup of class byte to class code
   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
   } lookup_type;

   function automatic lookup_type class_lookup(input logic [7:0] cls);
      lookup_type r;
      r = '{hit: 1'b1, kind: KIND_NAV};
      unique case (cls)
         CLASS_NAV: r.kind = KIND_NAV;
         CLASS_CFG: r.kind = KIND_CFG;
         CLASS_ACK: r.kind = KIND_ACK;
         default:   r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   // lookup of (class code, id byte) to message code
   function automatic lookup_type id_lookup(input logic [2:0] kind, input logic [7:0] id);
      lookup_type r;
      r = '{hit: 1'b0, kind: MSG_POSLLH};
      if (kind == KIND_NAV) begin
         r.hit = 1'b1;
         unique case (id)
            ID_POSLLH:  r.kind = MSG_POSLLH;
            ID_SOL:     r.kind = MSG_SOL;
            ID_TIMEUTC: r.kind = MSG_TIMEUTC;
            ID_SVINFO:  r.kind = MSG_SVINFO;
            ID_VELNED:  r.kind = MSG_VELNED;
            default:    r.hit  = 1'b0;
         endcase
      end else if (kind == KIND_CFG) begin
         r.hit  = (id == ID_NAV5);
         r.kind = MSG_NAV5;
      end else if (kind == KIND_ACK) begin
         if (id == ID_ACK) begin
            r.hit  = 1'b1;
            r.kind = MSG_ACK;
         end else if (id == ID_NAK) begin
            r.hit  = 1'b1;
            r.kind = MSG_NAK;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// Byte-serial UBX frame receiver with class/id filter and Fletcher-8 check.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one received byte per beat in req_tdata[7:0].
//   rsp_ channel returns exactly one beat per input byte: rsp_tuser holds
//   the status (none, payload, first check byte, good, bad sum, too long),
//   rsp_tdata holds message code, payload byte, byte index and declared
//   payload length.
//   A byte first lands in the input register when it is accepted, and its
//   result is then registered in the result register.
//   Throughput is one byte per cycle while rsp_tready stays high; the
//   parser steps its state once per byte, which sets that figure.
//   Reset clears the parser to hunting for the first sync byte and empties
//   both registers.
//   When the receiver holds rsp_tready low, the result register keeps its
//   beat, one more byte is taken into the input register, then req_tready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // [2:0] message_code, [10:3] payload_byte,
                                         // [26:11] byte_index, [42:27] payload_length,
                                         // [47:43] zero
   output      logic [2:0]  rsp_tuser    // [2:0] status
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   ubx_rx_pkg::result_type out_ff;
   ubx_rx_pkg::result_type step_result;
   logic                   advance;
   logic                   req_fire;

   // move a byte through when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   ubx_rx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   // result packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {5'd0, out_ff.payload_length, out_ff.byte_index,
                        out_ff.payload_byte, out_ff.message_code};

`ifndef NO_ASSERTIONS
   // a processed byte always shows up in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed byte produced no result");

   // a held input byte is not lost while the result stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");

   // payload data and index are zero on non-payload beats
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != ubx_rx_pkg::STATUS_PAYLOAD)
      |-> (out_ff.payload_byte == 8'd0 && out_ff.byte_index == 16'd0))
      else $error("payload fields set on non-payload beat");
`endif

endmodule

`default_nettype wire

// File: src/ubx_rx_parser.sv
// ----------------------------------------------------------------------------
// ubx_rx_parser
// Frame state machine with Fletcher-8 sums; one byte per step, result is
// combinational from the current state and byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_rx_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             rx_byte,
   output ubx_rx_pkg::result_type      result
);

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_SYNC1  = 3'd1,
      PH_SYNC2  = 3'd2,
      PH_CLASS  = 3'd3,
      PH_ID     = 3'd4,
      PH_LEN_LO = 3'd5,
      PH_BODY   = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [15:0] seen_ff, seen_in;
   logic [15:0] length_ff, length_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  check1_ff, check1_in;

   logic [7:0]             fold_a;
   logic [7:0]             fold_b;
   logic [16:0]            length_p1;
   ubx_rx_pkg::lookup_type cls_hit;
   ubx_rx_pkg::lookup_type id_hit;

   // running sums with this byte folded in
   assign fold_a    = sum_a_ff + rx_byte;
   assign fold_b    = sum_b_ff + fold_a;
   assign length_p1 = {1'b0, length_ff} + 17'd1;
   assign cls_hit   = ubx_rx_pkg::class_lookup(rx_byte);
   assign id_hit    = ubx_rx_pkg::id_lookup(kind_ff, rx_byte);

   // next state and result for the current byte
   always_comb begin
      phase_in  = phase_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      seen_in   = seen_ff;
      length_in = length_ff;
      kind_in   = kind_ff;
      check1_in = check1_ff;
      result    = '{status: ubx_rx_pkg::STATUS_NONE, message_code: 3'd0,
                    payload_byte: 8'd0, byte_index: 16'd0, payload_length: 16'd0};
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == ubx_rx_pkg::SYNC_FIRST) phase_in = PH_SYNC1;
         end
         PH_SYNC1: begin
            phase_in = (rx_byte == ubx_rx_pkg::SYNC_SECOND) ? PH_SYNC2 : PH_HUNT;
         end
         PH_SYNC2: begin
            if (cls_hit.hit) begin
               sum_a_in = fold_a;
               sum_b_in = fold_b;
               kind_in  = cls_hit.kind;
               phase_in = PH_CLASS;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_CLASS: begin
            if (id_hit.hit) begin
               sum_a_in            = fold_a;
               sum_b_in            = fold_b;
               kind_in             = id_hit.kind;
               phase_in            = PH_ID;
               result.message_code = id_hit.kind;
            end else begin
               phase_in = PH_HUNT;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
               kind_in  = 3'd0;
            end
         end
         PH_ID: begin
            sum_a_in            = fold_a;
            sum_b_in            = fold_b;
            length_in           = {8'd0, rx_byte};
            phase_in            = PH_LEN_LO;
            result.message_code = kind_ff;
         end
         PH_LEN_LO: begin
            sum_a_in              = fold_a;
            sum_b_in              = fold_b;
            length_in             = {rx_byte, length_ff[7:0]};
            phase_in              = PH_BODY;
            result.message_code   = kind_ff;
            result.payload_length = {rx_byte, length_ff[7:0]};
         end
         PH_BODY: begin
            result.message_code   = kind_ff;
            result.payload_length = length_ff;
            // frame end cases restore reset values
            priority if ({1'b0, seen_ff} >= ubx_rx_pkg::MAX_FRAME_LIMIT) begin
               result.status = ubx_rx_pkg::STATUS_TOO_LONG;
               phase_in = PH_HUNT;
            end else if ({1'b0, seen_ff} == length_p1) begin
               result.status = (sum_a_ff == check1_ff && sum_b_ff == rx_byte) ?
                               ubx_rx_pkg::STATUS_GOOD : ubx_rx_pkg::STATUS_BAD_SUM;
               phase_in = PH_HUNT;
            end else if (seen_ff == 16'hFFFF) begin
               result.status = ubx_rx_pkg::STATUS_TOO_LONG;
               phase_in = PH_HUNT;
            end else begin
               if (seen_ff < length_ff) begin
                  sum_a_in            = fold_a;
                  sum_b_in            = fold_b;
                  result.status       = ubx_rx_pkg::STATUS_PAYLOAD;
                  result.payload_byte = rx_byte;
                  result.byte_index   = seen_ff;
               end else begin
                  check1_in     = rx_byte;
                  result.status = ubx_rx_pkg::STATUS_CHECK1;
               end
               seen_in = seen_ff + 16'd1;
            end
            if (phase_in == PH_HUNT) begin
               sum_a_in  = 8'd0;
               sum_b_in  = 8'd0;
               seen_in   = 16'd0;
               length_in = 16'd0;
               kind_in   = 3'd0;
               check1_in = 8'd0;
            end
         end
         default: begin
            phase_in  = PH_HUNT;
            sum_a_in  = 8'd0;
            sum_b_in  = 8'd0;
            seen_in   = 16'd0;
            length_in = 16'd0;
            kind_in   = 3'd0;
            check1_in = 8'd0;
         end
      endcase
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         sum_a_ff  <= 8'd0;
         sum_b_ff  <= 8'd0;
         seen_ff   <= 16'd0;
         length_ff <= 16'd0;
         kind_ff   <= 3'd0;
         check1_ff <= 8'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         seen_ff   <= seen_in;
         length_ff <= length_in;
         kind_ff   <= kind_in;
         check1_ff <= check1_in;
      end
   end

`ifndef NO_ASSERTIONS
   // outside a frame body nothing is counted
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_BODY) |-> (seen_ff == 16'd0))
      else $error("byte count nonzero outside frame body");

   // a frame end leaves the parser hunting with clear sums
   assert property (@(posedge clock) disable iff (reset)
      (step && (result.status == ubx_rx_pkg::STATUS_GOOD ||
                result.status == ubx_rx_pkg::STATUS_BAD_SUM ||
                result.status == ubx_rx_pkg::STATUS_TOO_LONG))
      |=> (phase_ff == PH_HUNT && sum_a_ff == 8'd0 && sum_b_ff == 8'd0))
      else $error("frame end did not restart parser");

   // payload bytes stay inside the declared length
   assert property (@(posedge clock) disable iff (reset)
      (result.status == ubx_rx_pkg::STATUS_PAYLOAD) |-> (result.byte_index < length_ff))
      else $error("payload index beyond declared length");
`endif

endmodule

`default_nettype wire
